[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent assertion on the console engine clock and reset.
`define TCCE_ASSERT(lbl, prop, msg) `ASSERT_CLKD(lbl, clk_i, rst_ni, prop, msg)

`endif

[design/tcce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

  localparam int STORE_AW   = 12;
  localparam int CHAR_W     = 8;
  localparam int COLS_W     = 8;
  localparam int ROWS_W     = 6;
  localparam int CX_W       = 8;
  localparam int CY_W       = 6;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int OFF_W      = 12;
  localparam int WORD_W     = 16;

  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 32;

  localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd25;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7F;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] ATTR_BYTE  = 8'h0F;

  localparam int TAB_STEP = 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [CHAR_W-1:0]   wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

[design/tcce_cell_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcce_cell_ram (
  input  wire logic                       clk_i,
  input  wire tcce_pkg::mem_req_t         req_i,
  output logic [tcce_pkg::CHAR_W-1:0]     rdata_o
);
  import tcce_pkg::*;

  logic [CHAR_W-1:0] mem_q [2**STORE_AW];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/text_console_cursor_engine.sv]
// Text console cursor engine.
// Input channel (in_valid_i/in_ready_o) carries one item: an opcode (put character,
// clear screen, read cell), a character byte and a linear cell index. The output
// channel (out_valid_o/out_ready_i) returns one item per input item with the cursor
// column, row and linear offset, and for reads the cell word (attribute 0x0F, char).
// The cfg port writes the column count (index 0) and row count (index 1); write it
// only while no item is in flight.
// An ordinary item passes through an execute step, which updates the cursor and
// accesses the cell memory, and a finish step, which loads the output register and
// accepts the next item once the output register is free. A clear, or a put or
// other item that moves the cursor past the last row, walks the grid through the
// two-port cell memory one cell per cycle, covering rows * columns cells.
// Reset puts the cursor at (0,0) and the registers at 80 columns and 25 rows; the
// cell memory is not cleared, so a cell must be written before it is read.
// A finished result waits in the output register while the next item is accepted
// and worked on; that item then holds in its final cycle until the receiver takes
// the waiting result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module text_console_cursor_engine #(
  parameter int MAX_COLUMNS = tcce_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tcce_pkg::DEF_MAX_ROWS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tcce_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [tcce_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [tcce_pkg::OP_W-1:0]         opcode_i,
  input  wire logic [tcce_pkg::CHAR_W-1:0]       char_code_i,
  input  wire logic [tcce_pkg::STORE_AW-1:0]     cell_index_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [tcce_pkg::COL_OUT_W-1:0]         cursor_column_o,
  output logic [tcce_pkg::ROW_OUT_W-1:0]         cursor_row_o,
  output logic [tcce_pkg::OFF_W-1:0]             cursor_offset_o,
  output logic [tcce_pkg::WORD_W-1:0]            cell_word_o
);
  import tcce_pkg::*;

  localparam int EcW   = $clog2(MAX_COLUMNS + 1);
  localparam int ErW   = $clog2(MAX_ROWS + 1);
  localparam int CntW  = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
  localparam int PrW   = EcW + ErW;
  localparam int SwW   = (CntW + 1 > STORE_AW) ? CntW + 1 : STORE_AW;
  localparam int LinW  = (CY_W + EcW + 1 > STORE_AW) ? CY_W + EcW + 1 : STORE_AW;
  localparam int XP_W  = CX_W + 1;
  localparam int YP_W  = CY_W + 2;

  state_e state_q, state_d;

  logic [COLS_W-1:0]   columns_q;
  logic [ROWS_W-1:0]   rows_q;
  logic [CX_W-1:0]     cx_q, cx_d;
  logic [CY_W-1:0]     cy_q, cy_d;
  logic [OP_W-1:0]     op_q;
  logic [CHAR_W-1:0]   ch_q;
  logic [STORE_AW-1:0] idx_q;
  logic [CntW-1:0]     ptr_q, ptr_d;
  logic [CntW-1:0]     copy_q, copy_d;
  logic [CntW-1:0]     end_q, end_d;
  logic                pend_q;
  logic [STORE_AW-1:0] pend_addr_q;
  logic                pend_blank_q;
  logic                rd_cap_q, rd_cap_d;
  logic [CHAR_W-1:0]   hold_q;
  logic                out_valid_q;
  logic [COL_OUT_W-1:0] col_q;
  logic [ROW_OUT_W-1:0] row_q;
  logic [OFF_W-1:0]    off_q;
  logic [WORD_W-1:0]   word_q;

  logic [EcW-1:0]      eff_c;
  logic [ErW-1:0]      eff_r;
  logic [LinW-1:0]     lin;
  logic [PrW-1:0]      copy_prod;
  logic [CntW-1:0]     copy_n;
  logic [CntW-1:0]     end_n;
  logic [SwW-1:0]      ptr_ext;
  logic [SwW-1:0]      sweep_src;
  logic                sweep_copy;
  logic [XP_W-1:0]     x_p, x_s;
  logic [YP_W-1:0]     y_p, y_s1, y_m1, y_s;
  logic                printable;
  logic                scroll;
  logic                exec_wr;
  logic                in_ready;
  logic                out_load;
  logic [CHAR_W-1:0]   rdata;
  logic [CHAR_W-1:0]   cell_val;
  mem_req_t            mem_req;

  always_comb begin
    if (columns_q == '0) begin
      eff_c = EcW'(1);
    end else if (int'(columns_q) > MAX_COLUMNS) begin
      eff_c = EcW'(MAX_COLUMNS);
    end else begin
      eff_c = EcW'(columns_q);
    end
    if (rows_q == '0) begin
      eff_r = ErW'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      eff_r = ErW'(MAX_ROWS);
    end else begin
      eff_r = ErW'(rows_q);
    end
  end

  assign lin       = LinW'(cx_q) + LinW'(cy_q) * LinW'(eff_c);
  assign copy_prod = (PrW'(eff_r) - PrW'(1)) * PrW'(eff_c);
  assign copy_n    = CntW'(copy_prod);
  assign end_n     = copy_n + CntW'(eff_c);
  assign ptr_ext   = SwW'(ptr_q);
  assign sweep_src = ptr_ext + SwW'(eff_c);
  assign sweep_copy = ptr_q < copy_q;
  assign printable = ch_q inside {[PRINT_LO:PRINT_HI]};

  // Cursor move for the current item, then the column wrap and one-row scroll.
  always_comb begin
    x_p = XP_W'(cx_q);
    y_p = YP_W'(cy_q);
    case (op_q)
      OP_PUT: begin
        case (ch_q)
          CH_LF: begin
            x_p = '0;
            y_p = YP_W'(cy_q) + YP_W'(1);
          end
          CH_CR: begin
            x_p = '0;
          end
          CH_BS: begin
            if (cx_q != '0) begin
              x_p = XP_W'(cx_q) - XP_W'(1);
            end else if (cy_q != '0) begin
              x_p = XP_W'(eff_c) - XP_W'(1);
              y_p = YP_W'(cy_q) - YP_W'(1);
            end
          end
          CH_TAB: begin
            x_p = (XP_W'(cx_q) + XP_W'(TAB_STEP)) & ~XP_W'(TAB_STEP - 1);
          end
          default: begin
            if (printable) begin
              x_p = XP_W'(cx_q) + XP_W'(1);
            end
          end
        endcase
      end
      OP_CLEAR: begin
        x_p = '0;
        y_p = '0;
      end
      default: begin
        x_p = XP_W'(cx_q);
        y_p = YP_W'(cy_q);
      end
    endcase

    if (x_p >= XP_W'(eff_c)) begin
      x_s  = '0;
      y_s1 = y_p + YP_W'(1);
    end else begin
      x_s  = x_p;
      y_s1 = y_p;
    end
    scroll = y_s1 >= YP_W'(eff_r);
    y_m1   = y_s1 - YP_W'(1);
    if (!scroll) begin
      y_s = y_s1;
    end else if (y_m1 >= YP_W'(eff_r)) begin
      y_s = YP_W'(eff_r) - YP_W'(1);
    end else begin
      y_s = y_m1;
    end
  end

  assign exec_wr = (state_q == S_EXEC) && (op_q == OP_PUT) && printable;

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    out_load = 1'b0;
    cx_d     = cx_q;
    cy_d     = cy_q;
    ptr_d    = ptr_q;
    copy_d   = copy_q;
    end_d    = end_q;
    rd_cap_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cx_d     = x_s[CX_W-1:0];
        cy_d     = y_s[CY_W-1:0];
        ptr_d    = '0;
        copy_d   = scroll ? copy_n : '0;
        end_d    = end_n;
        rd_cap_d = (op_q == OP_READ);
        if (scroll || (op_q == OP_CLEAR)) begin
          state_d = S_SWEEP;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SWEEP: begin
        ptr_d = ptr_q + CntW'(1);
        if (ptr_q == end_q - CntW'(1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        out_load = !out_valid_q || out_ready_i;
        if (out_load) begin
          in_ready = 1'b1;
          state_d  = in_valid_i ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_req.we    = exec_wr || pend_q;
    mem_req.waddr = pend_q ? pend_addr_q : lin[STORE_AW-1:0];
    if (!pend_q) begin
      mem_req.wdata = ch_q;
    end else if (pend_blank_q) begin
      mem_req.wdata = BLANK_CHAR;
    end else begin
      mem_req.wdata = rdata;
    end
    if (state_q == S_SWEEP) begin
      mem_req.re    = sweep_copy;
      mem_req.raddr = sweep_src[STORE_AW-1:0];
    end else begin
      mem_req.re    = (state_q == S_EXEC) && (op_q == OP_READ);
      mem_req.raddr = idx_q;
    end
  end

  tcce_cell_ram u_cell_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign cell_val = rd_cap_q ? rdata : hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      columns_q   <= COLS_RESET;
      rows_q      <= ROWS_RESET;
      cx_q        <= '0;
      cy_q        <= '0;
      pend_q      <= 1'b0;
      rd_cap_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      pend_q   <= (state_q == S_SWEEP);
      rd_cap_q <= rd_cap_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COLUMNS: columns_q <= cfg_data_i[COLS_W-1:0];
          CFG_ROWS:    rows_q    <= cfg_data_i[ROWS_W-1:0];
          default:     columns_q <= columns_q;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      op_q  <= opcode_i;
      ch_q  <= char_code_i;
      idx_q <= cell_index_i;
    end
    ptr_q        <= ptr_d;
    copy_q       <= copy_d;
    end_q        <= end_d;
    pend_addr_q  <= ptr_ext[STORE_AW-1:0];
    pend_blank_q <= !sweep_copy;
    if (rd_cap_q) begin
      hold_q <= rdata;
    end
    if (out_load) begin
      col_q  <= cx_q[COL_OUT_W-1:0];
      row_q  <= cy_q[ROW_OUT_W-1:0];
      off_q  <= lin[OFF_W-1:0];
      word_q <= (op_q == OP_READ) ? {ATTR_BYTE, cell_val} : '0;
    end
  end

  assign in_ready_o      = in_ready;
  assign out_valid_o     = out_valid_q;
  assign cursor_column_o = col_q;
  assign cursor_row_o    = row_q;
  assign cursor_offset_o = off_q;
  assign cell_word_o     = word_q;

  `TCCE_ASSERT(a_accept_to_exec, (in_valid_i && in_ready_o) |=> (state_q == S_EXEC), "accepted item did not enter execution")
  `TCCE_ASSERT(a_pend_after_sweep, pend_q |-> ($past(state_q) == S_SWEEP), "grid write stage active without a sweep")
  `TCCE_ASSERT(a_sweep_in_bounds, (state_q == S_SWEEP) |-> (ptr_q < end_q), "sweep pointer ran past the grid")
  `TCCE_ASSERT(a_single_writer, !(exec_wr && pend_q), "character write collides with sweep write")
  `TCCE_ASSERT(a_result_from_finish, $rose(out_valid_q) |-> ($past(state_q) == S_FINISH), "result raised outside the finish step")

endmodule

`default_nettype wire

[tb/sv/tb_text_console_cursor_engine.sv]
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  localparam int STORE_DEPTH    = 1 << STORE_AW;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int HOLD_AFTER     = 500;
  localparam int HOLD_CYCLES    = 400;
  localparam int NUM_PHASES     = 10;
  localparam int MAX_REPORTED   = 10;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [COL_OUT_W-1:0] column;
    logic [ROW_OUT_W-1:0] row;
    logic [OFF_W-1:0]     offset;
    logic [WORD_W-1:0]    word;
  } cursor_report_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [CHAR_W-1:0]   ch;
    logic [STORE_AW-1:0] idx;
    logic                typed;
    cursor_report_t      report;
  } directed_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [OP_W-1:0]       opcode_i;
  logic [CHAR_W-1:0]     char_code_i;
  logic [STORE_AW-1:0]   cell_index_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [COL_OUT_W-1:0]  cursor_column_o;
  logic [ROW_OUT_W-1:0]  cursor_row_o;
  logic [OFF_W-1:0]      cursor_offset_o;
  logic [WORD_W-1:0]     cell_word_o;

  text_console_cursor_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .char_code_i    (char_code_i),
    .cell_index_i   (cell_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_column_o(cursor_column_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_offset_o(cursor_offset_o),
    .cell_word_o    (cell_word_o)
  );

  // Console shadow state. grid_set marks cells whose content is defined.
  logic [CHAR_W-1:0] grid_mem [STORE_DEPTH];
  bit                grid_set [STORE_DEPTH];
  logic [CX_W-1:0]   cur_x;
  logic [CY_W-1:0]   cur_y;
  logic [COLS_W-1:0] reg_cols;
  logic [ROWS_W-1:0] reg_rows;

  cursor_report_t pending_reports [$];
  directed_row_t  directed_rows [$];
  int             results_taken;
  int             mismatches;

  int phase_cols  [0:NUM_PHASES-1] = '{80, 128, 1, 0, 255, 7, 16, 40, 3, 100};
  int phase_rows  [0:NUM_PHASES-1] = '{25, 32, 1, 0, 63, 3, 4, 8, 17, 2};
  int phase_items [0:NUM_PHASES-1] = '{220, 120, 200, 100, 80, 250, 250, 200, 150, 150};
  bit phase_lead  [0:NUM_PHASES-1] = '{0, 1, 0, 0, 1, 1, 0, 1, 0, 1};

  wire in_fire  = in_valid_i & in_ready_o;
  wire out_fire = out_valid_o & out_ready_i;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int eff_cols();
    int c;
    c = int'(reg_cols);
    if (c < 1) c = 1;
    if (c > DEF_MAX_COLUMNS) c = DEF_MAX_COLUMNS;
    return c;
  endfunction

  function automatic int eff_rows();
    int r;
    r = int'(reg_rows);
    if (r < 1) r = 1;
    if (r > DEF_MAX_ROWS) r = DEF_MAX_ROWS;
    return r;
  endfunction

  function automatic void blank_cell(int addr);
    grid_mem[addr % STORE_DEPTH] = BLANK_CHAR;
    grid_set[addr % STORE_DEPTH] = 1'b1;
  endfunction

  // Wrap the column once, then scroll up once if the row ran off the grid.
  function automatic void settle_cursor(int x, int y);
    int c;
    int r;
    c = eff_cols();
    r = eff_rows();
    if (x >= c) begin
      y++;
      x = 0;
    end
    if (y >= r) begin
      for (int i = 0; i < (r - 1) * c; i++) begin
        grid_mem[i % STORE_DEPTH] = grid_mem[(i + c) % STORE_DEPTH];
        grid_set[i % STORE_DEPTH] = grid_set[(i + c) % STORE_DEPTH];
      end
      for (int i = (r - 1) * c; i < r * c; i++) blank_cell(i);
      y--;
      if (y >= r) y = r - 1;
    end
    cur_x = CX_W'(x);
    cur_y = CY_W'(y);
  endfunction

  function automatic cursor_report_t console_step(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                                  logic [STORE_AW-1:0] idx);
    cursor_report_t rep;
    int c;
    int x;
    int y;
    c = eff_cols();
    x = int'(cur_x);
    y = int'(cur_y);
    rep.word = '0;
    case (op)
      OP_PUT: begin
        case (ch)
          CH_LF: begin
            y++;
            x = 0;
          end
          CH_CR: x = 0;
          CH_BS: begin
            if (x != 0) begin
              x--;
            end else if (y != 0) begin
              y--;
              x = c - 1;
            end
          end
          CH_TAB: x = (x + TAB_STEP) & ~(TAB_STEP - 1);
          default: begin
            if (ch >= PRINT_LO && ch <= PRINT_HI) begin
              grid_mem[(x + y * c) % STORE_DEPTH] = ch;
              grid_set[(x + y * c) % STORE_DEPTH] = 1'b1;
              x++;
            end
          end
        endcase
        settle_cursor(x, y);
      end
      OP_CLEAR: begin
        for (int i = 0; i < c * eff_rows(); i++) blank_cell(i);
        settle_cursor(0, 0);
      end
      default: begin
        if (op == OP_READ) rep.word = {ATTR_BYTE, grid_mem[idx]};
        settle_cursor(x, y);
      end
    endcase
    rep.column = COL_OUT_W'(cur_x);
    rep.row    = ROW_OUT_W'(cur_y);
    rep.offset = OFF_W'(int'(cur_x) + int'(cur_y) * eff_cols());
    return rep;
  endfunction

  // Only cells with defined content are ever read back.
  function automatic int pick_cell();
    int cand;
    int start;
    for (int t = 0; t < 6; t++) begin
      if (t < 3) cand = $urandom_range(0, eff_cols() * eff_rows() - 1);
      else cand = $urandom_range(0, STORE_DEPTH - 1);
      if (grid_set[cand]) return cand;
    end
    start = $urandom_range(0, STORE_DEPTH - 1);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (grid_set[(start + i) % STORE_DEPTH]) return (start + i) % STORE_DEPTH;
    end
    return -1;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int k;
    k = $urandom_range(0, 99);
    if (k < 62) return CHAR_W'($urandom_range(int'(PRINT_LO), int'(PRINT_HI)));
    if (k < 72) return CH_LF;
    if (k < 76) return CH_CR;
    if (k < 83) return CH_BS;
    if (k < 89) return CH_TAB;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic int next_gap(inout bit burst, inout int run_left);
    if (run_left <= 0) begin
      burst = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(10, 60);
    end
    run_left--;
    if (burst) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 3);
  endfunction

  task automatic add_row(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch, logic [STORE_AW-1:0] idx,
                         logic typed, int col, int row, int off, int word);
    directed_row_t r;
    r.op = op;
    r.ch = ch;
    r.idx = idx;
    r.typed = typed;
    r.report = '{COL_OUT_W'(col), ROW_OUT_W'(row), OFF_W'(off), WORD_W'(word)};
    directed_rows.push_back(r);
  endtask

  task automatic send_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch, logic [STORE_AW-1:0] idx,
                           int gap, logic typed, cursor_report_t typed_report);
    cursor_report_t predicted;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    char_code_i  <= ch;
    cell_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = console_step(op, ch, idx);
    pending_reports.push_back(typed ? typed_report : predicted);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] which, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (which == CFG_COLUMNS) reg_cols = COLS_W'(value);
    else reg_rows = ROWS_W'(value);
  endtask

  task automatic drain_reports();
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    bit               drv_burst;
    int               drv_run;
    int               pick;
    int               cell_sel;
    int               clear_pct;
    logic [OP_W-1:0]  op;
    logic [CHAR_W-1:0] ch;
    logic [STORE_AW-1:0] idx;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_COLUMNS;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_PUT;
    char_code_i  = '0;
    cell_index_i = '0;
    drv_burst    = 1'b0;
    drv_run      = 0;
    cur_x        = '0;
    cur_y        = '0;
    reg_cols     = COLS_RESET;
    reg_rows     = ROWS_RESET;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      grid_mem[i] = '0;
      grid_set[i] = 1'b0;
    end

    add_row(OP_CLEAR, 8'h00, 12'd0,    1'b1, 0,  0, 0,  0);
    add_row(OP_READ,  8'hFF, 12'd0,    1'b1, 0,  0, 0,  16'h0F20);
    add_row(OP_READ,  8'h00, 12'd1999, 1'b1, 0,  0, 0,  16'h0F20);
    add_row(OP_PUT,   CH_BS, 12'd4095, 1'b1, 0,  0, 0,  0);
    add_row(OP_PUT,   8'h41, 12'd0,    1'b1, 1,  0, 1,  0);
    add_row(OP_READ,  8'h00, 12'd0,    1'b1, 1,  0, 1,  16'h0F41);
    add_row(OP_PUT,   8'h7F, 12'd0,    1'b1, 2,  0, 2,  0);
    add_row(OP_PUT,   8'h20, 12'd0,    1'b1, 3,  0, 3,  0);
    add_row(OP_PUT,   CH_TAB, 12'd0,   1'b1, 4,  0, 4,  0);
    add_row(OP_PUT,   CH_TAB, 12'd0,   1'b1, 8,  0, 8,  0);
    add_row(OP_PUT,   8'h80, 12'd0,    1'b1, 8,  0, 8,  0);
    add_row(OP_PUT,   8'hFF, 12'd0,    1'b1, 8,  0, 8,  0);
    add_row(OP_PUT,   8'h1F, 12'd0,    1'b1, 8,  0, 8,  0);
    add_row(OP_PUT,   8'h00, 12'd0,    1'b1, 8,  0, 8,  0);
    add_row(OP_PUT,   CH_CR, 12'd0,    1'b1, 0,  0, 0,  0);
    add_row(OP_PUT,   CH_LF, 12'd0,    1'b1, 0,  1, 80, 0);
    add_row(OP_PUT,   CH_BS, 12'd0,    1'b1, 79, 0, 79, 0);
    add_row(OP_PUT,   8'h5A, 12'd0,    1'b1, 0,  1, 80, 0);
    add_row(OP_READ,  8'h00, 12'd79,   1'b1, 0,  1, 80, 16'h0F5A);
    add_row(OP_SPARE, 8'hFF, 12'd4095, 1'b1, 0,  1, 80, 0);
    add_row(OP_READ,  8'h00, 12'd1,    1'b1, 0,  1, 80, 16'h0F7F);
    add_row(OP_PUT,   8'h7E, 12'd0,    1'b0, 0,  0, 0,  0);
    add_row(OP_PUT,   CH_LF, 12'd0,    1'b0, 0,  0, 0,  0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].idx,
                next_gap(drv_burst, drv_run), directed_rows[i].typed, directed_rows[i].report);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        drain_reports();
        repeat (4) @(negedge clk_i);
        write_reg(CFG_COLUMNS, CFG_DATA_W'(phase_cols[p]));
        write_reg(CFG_ROWS, CFG_DATA_W'(phase_rows[p]));
      end
      if (phase_lead[p]) begin
        send_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), '0, 0, 1'b0, '0);
        send_item(OP_READ, '0, STORE_AW'(eff_cols() * eff_rows() - 1), 0, 1'b0, '0);
      end
      clear_pct = (eff_cols() * eff_rows() > 1024) ? 1 : 3;
      for (int n = 0; n < phase_items[p]; n++) begin
        pick = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom_range(0, 255));
        idx  = STORE_AW'($urandom_range(0, STORE_DEPTH - 1));
        if (pick < clear_pct) begin
          op = OP_CLEAR;
        end else if (pick < clear_pct + 12) begin
          op = OP_READ;
          cell_sel = pick_cell();
          if (cell_sel < 0) op = OP_CLEAR;
          else idx = STORE_AW'(cell_sel);
        end else if (pick < clear_pct + 17) begin
          op = OP_SPARE;
        end else begin
          op = OP_PUT;
          ch = pick_char();
        end
        send_item(op, ch, idx, next_gap(drv_burst, drv_run), 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain_reports();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("[text_console_cursor_engine] OK");
    end else begin
      $display("[text_console_cursor_engine] ERROR");
    end
    $finish;
  end

  // The receiver stalls at random after each result, and once holds off for a long stretch.
  initial begin : result_sink
    int stall_left;
    int seen;
    bit burst;
    int run_left;
    stall_left  = 0;
    seen        = 0;
    burst       = 1'b0;
    run_left    = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (results_taken != seen) begin
        seen = results_taken;
        stall_left = (seen == HOLD_AFTER) ? HOLD_CYCLES : next_gap(burst, run_left);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    results_taken = 0;
    mismatches    = 0;
  end

  always @(posedge clk_i) begin
    cursor_report_t got;
    cursor_report_t want;
    if (rst_ni && out_fire) begin
      got = '{cursor_column_o, cursor_row_o, cursor_offset_o, cell_word_o};
      results_taken <= results_taken + 1;
      if (pending_reports.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTED) begin
          $display("unexpected result: col %0d row %0d offset %0d word %h",
                   got.column, got.row, got.offset, got.word);
        end
      end else begin
        want = pending_reports.pop_front();
        if (got.column !== want.column || got.row !== want.row ||
            got.offset !== want.offset || got.word !== want.word) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTED) begin
            $display("result %0d mismatch: col %0d/%0d row %0d/%0d offset %0d/%0d word %h/%h",
                     results_taken, want.column, got.column, want.row, got.row,
                     want.offset, got.offset, want.word, got.word);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[text_console_cursor_engine] ERROR");
    $finish;
  end

endmodule
